// ----- rtl/particle_update_step_defines.svh -----
// Assertion macros shared by the particle update checker
`ifndef PARTICLE_UPDATE_STEP_DEFINES_SVH
`define PARTICLE_UPDATE_STEP_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low
`define PUS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pus_chk: same-cycle check failed");

// Next-cycle implication, clocked on clk, off while rst_n is low
`define PUS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pus_chk: next-cycle check failed");

`endif

// ----- rtl/pus_pkg.sv -----
// Shared types, constants and saturation helpers for the particle update block
`default_nettype none

package pus_pkg;

    localparam int DEF_FRAC_BITS = 16;

    // Register map: index is paddr[2]
    localparam logic       REG_DT_STEP = 1'b0;
    localparam logic [15:0] DT_RESET   = 16'd1092;

    // Q0.16 constants
    localparam logic [15:0] K_GROW     = 16'd6554;
    localparam logic [15:0] K_DRAG_EXP = 16'd58982;
    localparam logic [15:0] K_DRAG_SPK = 16'd62259;

    typedef enum logic [1:0] {
        KIND_NONE      = 2'd0,
        KIND_SMOKE     = 2'd1,
        KIND_EXPLOSION = 2'd2,
        KIND_SPARK     = 2'd3
    } kind_t;

    // Particle record as it travels down the pipe
    typedef struct packed {
        kind_t            kind;
        logic             act;
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
        logic [30:0]      size;
        logic [31:0]      life;
        logic [23:0]      color;
    } rec_t;

    // Saturate to signed 32 bits
    function automatic logic [31:0] sat32(input logic signed [47:0] x);
        logic [31:0] r;
        if (x > 48'sh0000_7FFF_FFFF)
            r = 32'h7FFF_FFFF;
        else if (x < 48'shFFFF_8000_0000)
            r = 32'h8000_0000;
        else
            r = x[31:0];
        return r;
    endfunction

    // Clamp to unsigned 31 bits
    function automatic logic [30:0] satu31(input logic signed [47:0] x);
        logic [30:0] r;
        if (x < 48'sd0)
            r = '0;
        else if (x > 48'sh0000_7FFF_FFFF)
            r = 31'h7FFF_FFFF;
        else
            r = x[30:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/pus_in_if.sv -----
// Input channel: one particle record per word
`default_nettype none

interface pus_in_if;
    logic                 valid;
    logic                 ready;
    pus_pkg::kind_t       kind;
    logic signed [31:0]   pos_x;
    logic signed [31:0]   pos_y;
    logic signed [31:0]   pos_z;
    logic signed [31:0]   vel_x;
    logic signed [31:0]   vel_y;
    logic signed [31:0]   vel_z;
    logic [30:0]          size_in;
    logic signed [31:0]   life_in;
    logic [30:0]          life_start;
    logic [23:0]          color_rgb;

    modport source (
        output valid, kind, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
               size_in, life_in, life_start, color_rgb,
        input  ready
    );
    modport sink (
        input  valid, kind, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
               size_in, life_in, life_start, color_rgb,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/pus_out_if.sv -----
// Output channel: one updated particle record per word
`default_nettype none

interface pus_out_if;
    logic                 valid;
    logic                 ready;
    logic signed [31:0]   new_pos_x;
    logic signed [31:0]   new_pos_y;
    logic signed [31:0]   new_pos_z;
    logic signed [31:0]   new_vel_x;
    logic signed [31:0]   new_vel_y;
    logic signed [31:0]   new_vel_z;
    logic [30:0]          new_size;
    logic signed [31:0]   new_life;
    logic [23:0]          new_color_rgb;
    logic                 alive;

    modport source (
        output valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
               new_vel_z, new_size, new_life, new_color_rgb, alive,
        input  ready
    );
    modport sink (
        input  valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
               new_vel_z, new_size, new_life, new_color_rgb, alive,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/pus_div.sv -----
// Pipelined restoring divider: floor(num * 2^FRAC_BITS / den) for num < den
`default_nettype none

module pus_div #(
    parameter int FRAC_BITS = pus_pkg::DEF_FRAC_BITS
) (
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic [30:0]          num,
    input  wire logic [30:0]          den,
    output logic      [FRAC_BITS-1:0] quo
);

    // One quotient bit per stage
    logic [30:0]          rem_reg [FRAC_BITS];
    logic [30:0]          den_reg [FRAC_BITS];
    logic [FRAC_BITS-1:0] q_reg   [FRAC_BITS];

    logic [30:0]          rem_in  [FRAC_BITS];
    logic [30:0]          den_in  [FRAC_BITS];
    logic [FRAC_BITS-1:0] q_in    [FRAC_BITS];
    logic [30:0]          rem_next[FRAC_BITS];
    logic [FRAC_BITS-1:0] q_next  [FRAC_BITS];

    for (genvar i = 0; i < FRAC_BITS; i++) begin : g_stage
        // stage input: ports for the first stage, previous stage after that
        if (i == 0) begin : g_first
            assign rem_in[i] = num;
            assign den_in[i] = den;
            assign q_in[i]   = '0;
        end else begin : g_rest
            assign rem_in[i] = rem_reg[i-1];
            assign den_in[i] = den_reg[i-1];
            assign q_in[i]   = q_reg[i-1];
        end

        // shift, trial subtract, restore
        always_comb
        begin
            logic [31:0] r2;
            logic [31:0] dd;
            r2 = {rem_in[i], 1'b0};
            dd = {1'b0, den_in[i]};
            if (r2 >= dd)
            begin
                rem_next[i] = 31'(r2 - dd);
                q_next[i]   = {q_in[i][FRAC_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next[i] = r2[30:0];
                q_next[i]   = {q_in[i][FRAC_BITS-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= rem_next[i];
                den_reg[i] <= den_in[i];
                q_reg[i]   <= q_next[i];
            end
        end
    end

    assign quo = q_reg[FRAC_BITS-1];

endmodule

`default_nettype wire

// ----- rtl/particle_update_step.sv -----
// Top level of the particle update pipeline
//
// Advances one particle record by one frame step per word. The pipe takes a
// new record every cycle while the output is not stalled and delivers one
// result per record, in order; the pipe has FRAC_BITS + 4 register stages.
// The depth is set by the life ratio divider, which resolves one quotient
// bit per stage. A stall at the output freezes the whole pipe, so nothing
// is lost or repeated. dt_step sits at byte address 0 of the APB port and
// must only be written while no records are in flight.
`default_nettype none

module particle_update_step #(
    parameter int FRAC_BITS = pus_pkg::DEF_FRAC_BITS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    pus_in_if.sink           particle_in,
    pus_out_if.source        particle_out
);

    localparam int TW  = FRAC_BITS + 1;   // ratio, 0..1 inclusive
    localparam int DTW = 16 + FRAC_BITS;  // dt in life units
    localparam int GPW = DTW + 16;        // growth product
    localparam int TTW = 2 * TW;          // t squared
    localparam int CPW = 8 + TW;          // colour product
    localparam int PDW = TW + 16;         // impulse times dt
    localparam logic [TW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // ---------------- configuration ----------------
    logic [15:0] dt_reg;
    logic        cfg_wr;

    assign cfg_wr = psel && penable && pwrite && (paddr[2] == pus_pkg::REG_DT_STEP);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == pus_pkg::REG_DT_STEP) ? {16'b0, dt_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dt_reg <= pus_pkg::DT_RESET;
        else if (cfg_wr)
            dt_reg <= pwdata[15:0];
    end

    // dt-derived terms; keeping them static while records are in flight is up to the user
    logic [DTW-1:0]     dtf;
    logic [GPW-1:0]     grow_prod;
    logic signed [47:0] grow48;
    logic signed [47:0] shrink48;

    assign dtf       = DTW'({dt_reg, {FRAC_BITS{1'b0}}} >> 16);
    assign grow_prod = GPW'(dtf) * GPW'(pus_pkg::K_GROW);
    assign grow48    = $signed(48'(grow_prod >> 16));
    assign shrink48  = $signed(48'(dtf >> 1));

    // ---------------- flow control ----------------
    logic                 en;
    logic                 v1_reg;
    logic [FRAC_BITS-1:0] vch_reg;
    logic                 va_reg;
    logic                 vb_reg;
    logic                 out_v_reg;

    assign en                = !out_v_reg || particle_out.ready;
    assign particle_in.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            vch_reg   <= '0;
            va_reg    <= 1'b0;
            vb_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= particle_in.valid;
            vch_reg   <= {vch_reg[FRAC_BITS-2:0], v1_reg};
            va_reg    <= vch_reg[FRAC_BITS-1];
            vb_reg    <= va_reg;
            out_v_reg <= vb_reg;
        end
    end

    // ---------------- stage 1: capture, products, life ----------------
    pus_pkg::rec_t             s1_next;
    logic [2:0][48:0]          mv_next;
    logic [2:0][48:0]          md_next;
    logic [31:0]               ln_next;
    pus_pkg::rec_t             s1_rec_reg;
    logic [2:0][48:0]          s1_mv_reg;
    logic [2:0][48:0]          s1_md_reg;
    logic [31:0]               s1_ln_reg;
    logic [30:0]               s1_l0_reg;

    always_comb
    begin
        logic [15:0] kdrag;
        s1_next.kind  = particle_in.kind;
        s1_next.act   = !particle_in.life_in[31] && (|particle_in.life_in) &&
                        (particle_in.kind != pus_pkg::KIND_NONE);
        s1_next.pos   = {particle_in.pos_z, particle_in.pos_y, particle_in.pos_x};
        s1_next.vel   = {particle_in.vel_z, particle_in.vel_y, particle_in.vel_x};
        s1_next.size  = particle_in.size_in;
        s1_next.life  = particle_in.life_in;
        s1_next.color = particle_in.color_rgb;
        kdrag = (particle_in.kind == pus_pkg::KIND_EXPLOSION) ?
                pus_pkg::K_DRAG_EXP : pus_pkg::K_DRAG_SPK;
        for (int k = 0; k < 3; k++)
        begin
            mv_next[k] = 49'($signed({{17{s1_next.vel[k][31]}}, s1_next.vel[k]}) *
                             $signed({33'b0, dt_reg}));
            md_next[k] = 49'($signed({{17{s1_next.vel[k][31]}}, s1_next.vel[k]}) *
                             $signed({33'b0, kdrag}));
        end
        ln_next = pus_pkg::sat32($signed({{16{particle_in.life_in[31]}},
                                           particle_in.life_in}) -
                                 $signed(48'(dtf)));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_rec_reg <= s1_next;
            s1_mv_reg  <= mv_next;
            s1_md_reg  <= md_next;
            s1_ln_reg  <= ln_next;
            s1_l0_reg  <= particle_in.life_start;
        end
    end

    // ---------------- stage 2: position, drag, size, ratio setup ----------------
    pus_pkg::rec_t  s2_next;
    logic           fix_next;
    logic [TW-1:0]  fv_next;
    logic [30:0]    dnum_next;

    always_comb
    begin
        logic signed [47:0] psum;
        logic signed [47:0] size48;
        logic signed [33:0] num;
        logic               smoke;
        s2_next = s1_rec_reg;
        size48  = $signed({17'b0, s1_rec_reg.size});
        if (s1_rec_reg.act)
        begin
            for (int k = 0; k < 3; k++)
            begin
                psum = $signed({{16{s1_rec_reg.pos[k][31]}}, s1_rec_reg.pos[k]}) +
                       $signed({{15{s1_mv_reg[k][48]}}, s1_mv_reg[k][48:16]});
                s2_next.pos[k] = pus_pkg::sat32(psum);
            end
            s2_next.life = s1_ln_reg;
            case (s1_rec_reg.kind)
                pus_pkg::KIND_SMOKE:
                    s2_next.size = pus_pkg::satu31(size48 + grow48);
                pus_pkg::KIND_EXPLOSION:
                begin
                    s2_next.size = pus_pkg::satu31(size48 - shrink48);
                    for (int k = 0; k < 3; k++)
                        s2_next.vel[k] = s1_md_reg[k][47:16];
                end
                pus_pkg::KIND_SPARK:
                    for (int k = 0; k < 3; k++)
                        s2_next.vel[k] = s1_md_reg[k][47:16];
                default: ;
            endcase
        end

        // ratio numerator: smoke uses elapsed life, explosion remaining life
        smoke = (s1_rec_reg.kind == pus_pkg::KIND_SMOKE);
        if (smoke)
            num = $signed({3'b000, s1_l0_reg}) -
                  $signed({{2{s1_ln_reg[31]}}, s1_ln_reg});
        else
            num = $signed({{2{s1_ln_reg[31]}}, s1_ln_reg});

        dnum_next = '0;
        if (s1_l0_reg == '0)
        begin
            fix_next = 1'b1;
            fv_next  = smoke ? ONE : '0;
        end
        else if (num[33] || (num == '0))
        begin
            fix_next = 1'b1;
            fv_next  = '0;
        end
        else if (num >= $signed({3'b000, s1_l0_reg}))
        begin
            fix_next = 1'b1;
            fv_next  = ONE;
        end
        else
        begin
            fix_next  = 1'b0;
            fv_next   = '0;
            dnum_next = num[30:0];
        end
    end

    // ---------------- divider and matching delay line ----------------
    logic [FRAC_BITS-1:0] quo;
    pus_pkg::rec_t        ch_rec_reg [FRAC_BITS];
    logic                 ch_fix_reg [FRAC_BITS];
    logic [TW-1:0]        ch_fv_reg  [FRAC_BITS];

    pus_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk (clk),
        .en  (en),
        .num (dnum_next),
        .den (s1_l0_reg),
        .quo (quo)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ch_rec_reg[0] <= s2_next;
            ch_fix_reg[0] <= fix_next;
            ch_fv_reg[0]  <= fv_next;
            for (int i = 1; i < FRAC_BITS; i++)
            begin
                ch_rec_reg[i] <= ch_rec_reg[i-1];
                ch_fix_reg[i] <= ch_fix_reg[i-1];
                ch_fv_reg[i]  <= ch_fv_reg[i-1];
            end
        end
    end

    // ---------------- stage A: t squared, colour products ----------------
    logic [TW-1:0]          t_w;
    logic [TTW-1:0]         tt_next;
    logic [2:0][CPW-1:0]    cp_next;
    pus_pkg::rec_t          a_rec_reg;
    logic [TTW-1:0]         a_tt_reg;
    logic [2:0][CPW-1:0]    a_cp_reg;

    assign t_w = ch_fix_reg[FRAC_BITS-1] ? ch_fv_reg[FRAC_BITS-1] : {1'b0, quo};

    always_comb
    begin
        tt_next = TTW'(t_w) * TTW'(t_w);
        for (int k = 0; k < 3; k++)
            cp_next[k] = CPW'(ch_rec_reg[FRAC_BITS-1].color[8*k +: 8]) * CPW'(t_w);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_rec_reg <= ch_rec_reg[FRAC_BITS-1];
            a_tt_reg  <= tt_next;
            a_cp_reg  <= cp_next;
        end
    end

    // ---------------- stage B: upward impulse times dt ----------------
    logic [TW-1:0]       imp_w;
    logic [PDW-1:0]      pdt_next;
    pus_pkg::rec_t       b_rec_reg;
    logic [PDW-1:0]      b_pdt_reg;
    logic [2:0][CPW-1:0] b_cp_reg;

    assign imp_w    = ONE - TW'(a_tt_reg >> FRAC_BITS);
    assign pdt_next = PDW'(imp_w) * PDW'(dt_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_rec_reg <= a_rec_reg;
            b_pdt_reg <= pdt_next;
            b_cp_reg  <= a_cp_reg;
        end
    end

    // ---------------- stage C: final smoke lift and colour fade ----------------
    pus_pkg::rec_t out_next;
    pus_pkg::rec_t out_rec_reg;

    always_comb
    begin
        out_next = b_rec_reg;
        if (b_rec_reg.act && (b_rec_reg.kind == pus_pkg::KIND_SMOKE))
            out_next.vel[1] = pus_pkg::sat32(
                $signed({{16{b_rec_reg.vel[1][31]}}, b_rec_reg.vel[1]}) +
                $signed(48'(b_pdt_reg >> 16)));
        if (b_rec_reg.act && (b_rec_reg.kind == pus_pkg::KIND_EXPLOSION))
            for (int k = 0; k < 3; k++)
                out_next.color[8*k +: 8] = 8'(b_cp_reg[k] >> FRAC_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_rec_reg <= out_next;
    end

    // ---------------- output word ----------------
    assign particle_out.valid         = out_v_reg;
    assign particle_out.new_pos_x     = out_rec_reg.pos[0];
    assign particle_out.new_pos_y     = out_rec_reg.pos[1];
    assign particle_out.new_pos_z     = out_rec_reg.pos[2];
    assign particle_out.new_vel_x     = out_rec_reg.vel[0];
    assign particle_out.new_vel_y     = out_rec_reg.vel[1];
    assign particle_out.new_vel_z     = out_rec_reg.vel[2];
    assign particle_out.new_size      = out_rec_reg.size;
    assign particle_out.new_life      = out_rec_reg.life;
    assign particle_out.new_color_rgb = out_rec_reg.color;
    assign particle_out.alive         = !out_rec_reg.life[31] && (|out_rec_reg.life);

endmodule

`default_nettype wire

// ----- rtl/pus_chk.sv -----
// Port-level checker for the particle update pipeline, bound to the top level
`default_nettype none
`include "particle_update_step_defines.svh"

module pus_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        alive,
    input wire logic [31:0] new_life
);

    // empty output register always lets a word in
    `PUS_ASSERT_IMP(a_ready_when_empty, !out_valid, in_ready)
    // a stalled output freezes the whole pipe
    `PUS_ASSERT_IMP(a_stall_blocks_input, out_valid && !out_ready, !in_ready)
    // alive flag agrees with the delivered life
    `PUS_ASSERT_IMP(a_alive_matches_life, out_valid, alive == ($signed(new_life) > 0))
    // a result waiting at the output stays there
    `PUS_ASSERT_NEXT(a_out_holds, out_valid && !out_ready, out_valid)

endmodule

bind particle_update_step pus_chk u_pus_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (particle_in.ready),
    .out_valid (particle_out.valid),
    .out_ready (particle_out.ready),
    .alive     (particle_out.alive),
    .new_life  (particle_out.new_life)
);

`default_nettype wire

// ----- verif/tb_top.sv -----
// Self-checking testbench for the particle update pipeline
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
    import pus_pkg::*;

    localparam int FB       = 16;
    localparam int LATENCY  = FB + 4;
    localparam int WDOG_MAX = 20000;

    typedef struct {
        kind_t       kind;
        logic [31:0] pos[3];
        logic [31:0] vel[3];
        logic [30:0] size;
        logic [31:0] life;
        logic [30:0] life0;
        logic [23:0] color;
    } particle_t;

    typedef struct {
        logic [31:0] pos[3];
        logic [31:0] vel[3];
        logic [30:0] size;
        logic [31:0] life;
        logic [23:0] color;
        logic        alive;
    } step_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    pus_in_if  particle_in ();
    pus_out_if particle_out ();

    particle_update_step dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .particle_in  (particle_in.sink),
        .particle_out (particle_out.source)
    );

    particle_t pending_q[$];
    step_t     expected_q[$];
    logic [15:0] dt_reg;
    int  src_idle_pct;
    int  snk_stall_pct;
    int  errors;
    int  idle_cycles;

    // Clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // floor(x / 2^sh), arithmetic shift floors already
    function automatic longint fshr(input longint x, input int sh);
        return x >>> sh;
    endfunction

    function automatic longint clampl(input longint x, input longint lo, input longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    function automatic longint life_ratio(input longint num, input longint den,
                                          input longint zero_val);
        if (den <= 0)
            return zero_val;
        if (num <= 0)
            return 0;
        if (num >= den)
            return longint'(1) << FB;
        return (num << FB) / den;
    endfunction

    // Expected record after one frame step
    function automatic step_t advance_particle(input particle_t p, input logic [15:0] dt);
        step_t  r;
        longint pos[3];
        longint vel[3];
        longint size;
        longint life;
        longint life0;
        longint one;
        longint dtl;
        longint dtf;
        longint t;
        longint imp;
        longint f;
        longint c;
        logic [23:0] nc;
        one   = longint'(1) << FB;
        dtl   = longint'(dt);
        dtf   = (dtl << FB) >>> 16;
        for (int i = 0; i < 3; i++)
        begin
            pos[i] = longint'(signed'(p.pos[i]));
            vel[i] = longint'(signed'(p.vel[i]));
        end
        size  = longint'(p.size);
        life  = longint'(signed'(p.life));
        life0 = longint'(p.life0);
        r.color = p.color;
        if (life > 0 && p.kind != KIND_NONE)
        begin
            for (int i = 0; i < 3; i++)
                pos[i] = clampl(pos[i] + fshr(vel[i] * dtl, 16), -64'sd2147483648,
                                64'sd2147483647);
            life = clampl(life - dtf, -64'sd2147483648, 64'sd2147483647);
            case (p.kind)
                KIND_SMOKE:
                begin
                    t       = life_ratio(life0 - life, life0, one);
                    imp     = one - fshr(t * t, FB);
                    size    = clampl(size + fshr(longint'(K_GROW) * dtf, 16), 0, 64'sd2147483647);
                    vel[1]  = clampl(vel[1] + fshr(imp * dtl, 16), -64'sd2147483648,
                                     64'sd2147483647);
                end
                KIND_EXPLOSION:
                begin
                    f    = life_ratio(life, life0, 0);
                    size = clampl(size - (dtf >>> 1), 0, 64'sd2147483647);
                    for (int i = 0; i < 3; i++)
                        vel[i] = fshr(vel[i] * longint'(K_DRAG_EXP), 16);
                    for (int ch = 0; ch < 3; ch++)
                    begin
                        c = longint'(p.color[ch*8 +: 8]);
                        nc[ch*8 +: 8] = 8'(fshr(c * f, FB));
                    end
                    r.color = nc;
                end
                default:
                begin
                    for (int i = 0; i < 3; i++)
                        vel[i] = fshr(vel[i] * longint'(K_DRAG_SPK), 16);
                end
            endcase
        end
        for (int i = 0; i < 3; i++)
        begin
            r.pos[i] = 32'(pos[i]);
            r.vel[i] = 32'(vel[i]);
        end
        r.size  = 31'(size);
        r.life  = 32'(life);
        r.alive = (life > 0);
        return r;
    endfunction

    function automatic logic [31:0] rand_s32();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'(int'($urandom_range(0, 400000)) - 200000);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [30:0] rand_u31();
        case ($urandom_range(0, 4))
            0: return 31'h7FFF_FFFF;
            1: return 31'd0;
            2: return 31'($urandom_range(0, 600000));
            default: return 31'($urandom());
        endcase
    endfunction

    function automatic particle_t rand_particle();
        particle_t p;
        p.kind = kind_t'($urandom_range(0, 3));
        for (int i = 0; i < 3; i++)
        begin
            p.pos[i] = rand_s32();
            p.vel[i] = rand_s32();
        end
        p.size  = rand_u31();
        p.life0 = rand_u31();
        // mostly live, with life below and around life0
        case ($urandom_range(0, 7))
            0: p.life = rand_s32();
            1: p.life = 32'($urandom_range(0, 3000));
            default: p.life = 32'($urandom_range(0, 32'(p.life0) + 1000));
        endcase
        p.color = 24'($urandom());
        return p;
    endfunction

    function automatic particle_t make_particle(input kind_t k, input logic [31:0] v,
                                                input logic [31:0] lf,
                                                input logic [30:0] l0);
        particle_t p;
        p.kind = k;
        for (int i = 0; i < 3; i++)
        begin
            p.pos[i] = v;
            p.vel[i] = v;
        end
        p.size  = 31'h7FFF_FFFF;
        p.life  = lf;
        p.life0 = l0;
        p.color = 24'hFF80_01;
        return p;
    endfunction

    // Input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            particle_in.valid <= 1'b0;
        end
        else if (!particle_in.valid || particle_in.ready)
        begin
            if (pending_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct)
            begin
                particle_t p;
                p = pending_q.pop_front();
                expected_q.push_back(advance_particle(p, dt_reg));
                particle_in.valid      <= 1'b1;
                particle_in.kind       <= p.kind;
                particle_in.pos_x      <= p.pos[0];
                particle_in.pos_y      <= p.pos[1];
                particle_in.pos_z      <= p.pos[2];
                particle_in.vel_x      <= p.vel[0];
                particle_in.vel_y      <= p.vel[1];
                particle_in.vel_z      <= p.vel[2];
                particle_in.size_in    <= p.size;
                particle_in.life_in    <= p.life;
                particle_in.life_start <= p.life0;
                particle_in.color_rgb  <= p.color;
            end
            else
            begin
                particle_in.valid <= 1'b0;
            end
        end
    end

    // Output monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            particle_out.ready <= 1'b0;
            idle_cycles        <= 0;
        end
        else
        begin
            particle_out.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
            if ((particle_in.valid && particle_in.ready) ||
                (particle_out.valid && particle_out.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (particle_out.valid && particle_out.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected word out, new_pos_x %h", $time,
                             particle_out.new_pos_x);
                    errors <= errors + 1;
                end
                else
                begin
                    step_t e;
                    step_t a;
                    e = expected_q.pop_front();
                    a.pos[0] = particle_out.new_pos_x;
                    a.pos[1] = particle_out.new_pos_y;
                    a.pos[2] = particle_out.new_pos_z;
                    a.vel[0] = particle_out.new_vel_x;
                    a.vel[1] = particle_out.new_vel_y;
                    a.vel[2] = particle_out.new_vel_z;
                    a.size   = particle_out.new_size;
                    a.life   = particle_out.new_life;
                    a.color  = particle_out.new_color_rgb;
                    a.alive  = particle_out.alive;
                    if (a.pos[0] !== e.pos[0] || a.pos[1] !== e.pos[1] ||
                        a.pos[2] !== e.pos[2] || a.vel[0] !== e.vel[0] ||
                        a.vel[1] !== e.vel[1] || a.vel[2] !== e.vel[2] ||
                        a.size !== e.size || a.life !== e.life ||
                        a.color !== e.color || a.alive !== e.alive)
                    begin
                        $display("%0t: mismatch exp pos %h %h %h vel %h %h %h size %h life %h col %h alive %b",
                                 $time, e.pos[0], e.pos[1], e.pos[2], e.vel[0], e.vel[1],
                                 e.vel[2], e.size, e.life, e.color, e.alive);
                        $display("%0t:          act pos %h %h %h vel %h %h %h size %h life %h col %h alive %b",
                                 $time, a.pos[0], a.pos[1], a.pos[2], a.vel[0], a.vel[1],
                                 a.vel[2], a.size, a.life, a.color, a.alive);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

    // Watchdog on lack of progress
    always @(posedge clk)
    begin
        if (idle_cycles >= WDOG_MAX)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // APB register write, block idle
    task automatic write_dt(input logic [15:0] v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'({REG_DT_STEP, 2'b00});
        pwdata  <= {16'd0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        dt_reg  = v;
    endtask

    // Waits until every queued record is sent and every expected word has come back
    task automatic drain();
        while (pending_q.size() != 0 || particle_in.valid || expected_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic random_burst(input int n);
        for (int i = 0; i < n; i++)
            pending_q.push_back(rand_particle());
    endtask

    // Stimulus sequence
    initial
    begin
        logic [31:0] ext[4];
        errors        = 0;
        dt_reg        = DT_RESET;
        src_idle_pct  = 15;
        snk_stall_pct = 47;
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        particle_in.valid      = 1'b0;
        particle_in.kind       = KIND_NONE;
        particle_in.pos_x      = '0;
        particle_in.pos_y      = '0;
        particle_in.pos_z      = '0;
        particle_in.vel_x      = '0;
        particle_in.vel_y      = '0;
        particle_in.vel_z      = '0;
        particle_in.size_in    = '0;
        particle_in.life_in    = '0;
        particle_in.life_start = '0;
        particle_in.color_rgb  = '0;
        particle_out.ready     = 1'b0;
        repeat (3) @(posedge clk);
        rst_n = 1'b1;

        // Directed: reset dt, every kind at the field extremes, dead and zero life0
        ext = '{32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'hFFFF_FFFF};
        for (int k = 0; k < 4; k++)
            for (int j = 0; j < 4; j++)
                pending_q.push_back(make_particle(kind_t'(k), ext[j], 32'h7FFF_FFFF,
                                                  31'h7FFF_FFFF));
        pending_q.push_back(make_particle(KIND_SMOKE, 32'h10000, 32'd100, 31'd0));
        pending_q.push_back(make_particle(KIND_EXPLOSION, 32'h10000, 32'd100, 31'd0));
        pending_q.push_back(make_particle(KIND_SPARK, 32'h10000, 32'd0, 31'd50));
        pending_q.push_back(make_particle(KIND_SMOKE, 32'h10000, 32'h8000_0000, 31'd50));
        pending_q.push_back(make_particle(KIND_EXPLOSION, 32'h10000, 32'd1, 31'd1000));
        pending_q.push_back(make_particle(KIND_NONE, 32'h10000, 32'd5, 31'd5));
        drain();

        // Largest step
        write_dt(16'hFFFF);
        pending_q.push_back(make_particle(KIND_SMOKE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'd1));
        pending_q.push_back(make_particle(KIND_EXPLOSION, 32'h8000_0000, 32'd100, 31'd200));
        random_burst(80);
        drain();

        // Zero step, receiver and sender swap their idling
        write_dt(16'd0);
        src_idle_pct  = 47;
        snk_stall_pct = 15;
        random_burst(60);
        drain();

        // Random step values, no idling
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        for (int ph = 0; ph < 4; ph++)
        begin
            write_dt(16'($urandom()));
            random_burst(50);
            drain();
        end

        // Back to the default step
        write_dt(DT_RESET);
        random_burst(50);
        drain();

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

// ----- particle_update_step.f -----
+incdir+rtl
rtl/pus_pkg.sv
rtl/pus_in_if.sv
rtl/pus_out_if.sv
rtl/pus_div.sv
rtl/particle_update_step.sv
rtl/pus_chk.sv
verif/tb_top.sv
